// File: rtl/adc_pkg.sv
package adc_pkg;

    // table depth default
    localparam int TABLE_ENTRIES_DEF = 8;

    // configuration register indexes
    localparam logic [1:0] REG_OWN_NODE_ID    = 2'd0;
    localparam logic [1:0] REG_FORGET_TIME_MS = 2'd1;
    localparam logic [1:0] REG_ACTIVE_TIME_MS = 2'd2;

    // configuration reset values
    localparam logic [31:0] OWN_NODE_ID_RST    = 32'd0;
    localparam logic [31:0] FORGET_TIME_MS_RST = 32'd60000;
    localparam logic [31:0] ACTIVE_TIME_MS_RST = 32'd30000;

    // command codes
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    // report status codes
    localparam logic [2:0] ST_NONE   = 3'd0;
    localparam logic [2:0] ST_NEW    = 3'd1;
    localparam logic [2:0] ST_RAISED = 3'd2;
    localparam logic [2:0] ST_STALE  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    // one table entry
    typedef struct packed {
        logic [31:0] src_id;
        logic [31:0] max_seq;
        logic [31:0] last_ms;
    } t_entry;

endpackage

// File: rtl/adc_table.sv
module adc_table #(
    parameter int ENTRIES = adc_pkg::TABLE_ENTRIES_DEF,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  logic [AW-1:0]  i_rd_addr,
    output adc_pkg::t_entry o_rd_entry,
    output logic           o_rd_occ,
    input  logic           i_wr_en,
    input  logic           i_clr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  adc_pkg::t_entry i_wr_entry
);

    adc_pkg::t_entry r_mem [ENTRIES];
    adc_pkg::t_entry r_rd_entry;
    logic [ENTRIES-1:0] r_valid;
    logic r_rd_occ;

    // entry storage, no reset needed since occupancy lives in r_valid
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    // occupancy bits, cleared at once by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_occ <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_clr_en) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_occ <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_occ   = r_rd_occ;

endmodule

// File: rtl/alarm_dedup_cache_top.sv
// Alarm duplicate-suppression table. Each transfer on the input channel is either an alarm
// report (command 0) or an aging sweep (command 1), and each yields exactly one result
// transfer carrying the report status and the first still-active entry in slot order.
// Entries live in a table with one read and one write port, read one slot per cycle; a small
// sequencer walks the slots through one shared 32-bit compare unit. A report's lookup ends
// early on a source hit, a sweep always visits every slot, and both then run the
// active-entry search, which ends early at the first active entry, before a handoff to the
// output register; the walk is paced by the one-slot-per-cycle table read port. The input
// is ready only while the sequencer idles; a finished result sits in an output register so
// the next item can be taken while it waits. Occupancy bits are cleared by reset, so no
// clearing pass is needed. Configuration writes are registered and must only happen while
// idle.
module alarm_dedup_cache_top #(
    parameter int TABLE_ENTRIES = adc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_source_id,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_now_ms,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_report_status,
    output logic        o_alarm_active,
    output logic [31:0] o_alarm_source,
    output logic [31:0] o_alarm_seq
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // report lookup
    localparam logic [2:0] S_SWEEP = 3'd2;  // aging sweep
    localparam logic [2:0] S_ACT   = 3'd3;  // first active entry search
    localparam logic [2:0] S_DONE  = 3'd4;  // hand result to output register

    // configuration
    logic [31:0] r_own_id, r_forget_ms, r_active_ms;

    // latched item
    logic        r_cmd, n_cmd;
    logic [31:0] r_src, n_src;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_now, n_now;

    // sequencer
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_addr, n_addr;     // next slot to read
    logic          r_pend, n_pend;     // read data valid this cycle
    logic [AW-1:0] r_eidx, n_eidx;     // slot of the read data
    logic          r_have_free, n_have_free;
    logic [AW-1:0] r_free, n_free;

    // result being built
    logic [2:0]  r_status, n_status;
    logic        r_act, n_act;
    logic [31:0] r_asrc, n_asrc;
    logic [31:0] r_aseq, n_aseq;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_o_status, n_o_status;
    logic        r_o_act, n_o_act;
    logic [31:0] r_o_src, n_o_src;
    logic [31:0] r_o_seq, n_o_seq;

    // table interface
    logic            rd_en;
    adc_pkg::t_entry rd_entry;
    logic            rd_occ;
    logic            wr_en, clr_en;
    logic [AW-1:0]   wr_addr;
    adc_pkg::t_entry wr_entry;

    // shared compare unit
    logic [31:0] age, cmp_a, cmp_b;
    logic        cmp_gt;

    logic issue, last, hit, in_xfer;

    adc_table #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_addr[AW-1:0]),
        .o_rd_entry (rd_entry),
        .o_rd_occ   (rd_occ),
        .i_wr_en    (wr_en),
        .i_clr_en   (clr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry)
    );

    // configuration registers, out-of-range index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= adc_pkg::OWN_NODE_ID_RST;
            r_forget_ms <= adc_pkg::FORGET_TIME_MS_RST;
            r_active_ms <= adc_pkg::ACTIVE_TIME_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                adc_pkg::REG_OWN_NODE_ID:    r_own_id    <= i_cfg_data;
                adc_pkg::REG_FORGET_TIME_MS: r_forget_ms <= i_cfg_data;
                adc_pkg::REG_ACTIVE_TIME_MS: r_active_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // slot walk: read slot r_addr while looking at slot r_eidx
    assign issue = (r_addr < CW'(TABLE_ENTRIES));
    assign rd_en = issue && (r_state inside {S_SCAN, S_SWEEP, S_ACT});
    assign last  = (r_eidx == AW'(TABLE_ENTRIES - 1));
    assign hit   = rd_occ && (rd_entry.src_id == r_src);

    // age wraps modulo 2^32
    assign age = r_now - rd_entry.last_ms;

    always_comb begin
        case (r_state)
            S_SCAN: begin
                cmp_a = r_seq;
                cmp_b = rd_entry.max_seq;
            end
            S_SWEEP: begin
                cmp_a = age;
                cmp_b = r_forget_ms;
            end
            default: begin
                cmp_a = age;
                cmp_b = r_active_ms;
            end
        endcase
    end
    assign cmp_gt = (cmp_a > cmp_b);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_eidx      = r_eidx;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_cmd       = r_cmd;
        n_src       = r_src;
        n_seq       = r_seq;
        n_now       = r_now;
        n_status    = r_status;
        n_act       = r_act;
        n_asrc      = r_asrc;
        n_aseq      = r_aseq;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_act     = r_o_act;
        n_o_src     = r_o_src;
        n_o_seq     = r_o_seq;
        wr_en       = 1'b0;
        clr_en      = 1'b0;
        wr_addr     = r_eidx;
        wr_entry    = '{src_id: r_src, max_seq: r_seq, last_ms: r_now};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // advance the slot pipeline in every walking state
        if (r_state inside {S_SCAN, S_SWEEP, S_ACT}) begin
            n_pend = issue;
            n_eidx = r_addr[AW-1:0];
            if (issue) begin
                n_addr = r_addr + CW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd       = i_command;
                    n_src       = i_source_id;
                    n_seq       = i_seq_num;
                    n_now       = i_now_ms;
                    n_addr      = '0;
                    n_pend      = 1'b0;
                    n_have_free = 1'b0;
                    n_status    = adc_pkg::ST_NONE;
                    if (i_command == adc_pkg::CMD_SWEEP) begin
                        n_state = S_SWEEP;
                    end else if (i_source_id == 32'd0 || i_source_id == r_own_id) begin
                        // ignored report goes straight to the active search
                        n_state = S_ACT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (hit) begin
                        if (cmp_gt) begin
                            wr_en    = 1'b1;
                            wr_entry = '{src_id: rd_entry.src_id, max_seq: r_seq,
                                         last_ms: r_now};
                            n_status = adc_pkg::ST_RAISED;
                        end else begin
                            n_status = adc_pkg::ST_STALE;
                        end
                        n_state = S_ACT;
                        n_addr  = '0;
                        n_pend  = 1'b0;
                    end else begin
                        if (!rd_occ && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free      = r_eidx;
                        end
                        if (last) begin
                            if (r_have_free || !rd_occ) begin
                                wr_en    = 1'b1;
                                wr_addr  = r_have_free ? r_free : r_eidx;
                                n_status = adc_pkg::ST_NEW;
                            end else begin
                                n_status = adc_pkg::ST_FULL;
                            end
                            n_state = S_ACT;
                            n_addr  = '0;
                            n_pend  = 1'b0;
                        end
                    end
                end
            end
            S_SWEEP: begin
                if (r_pend) begin
                    // emptied slot keeps its stored entry, only occupancy drops
                    if (rd_occ && cmp_gt) begin
                        clr_en = 1'b1;
                    end
                    if (last) begin
                        n_state = S_ACT;
                        n_addr  = '0;
                        n_pend  = 1'b0;
                    end
                end
            end
            S_ACT: begin
                if (r_pend) begin
                    if (rd_occ && !cmp_gt) begin
                        n_act   = 1'b1;
                        n_asrc  = rd_entry.src_id;
                        n_aseq  = rd_entry.max_seq;
                        n_state = S_DONE;
                    end else if (last) begin
                        n_act   = 1'b0;
                        n_asrc  = '0;
                        n_aseq  = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_act     = r_act;
                    n_o_src     = r_asrc;
                    n_o_seq     = r_aseq;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_have_free <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_have_free <= n_have_free;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_eidx     <= n_eidx;
        r_free     <= n_free;
        r_cmd      <= n_cmd;
        r_src      <= n_src;
        r_seq      <= n_seq;
        r_now      <= n_now;
        r_status   <= n_status;
        r_act      <= n_act;
        r_asrc     <= n_asrc;
        r_aseq     <= n_aseq;
        r_o_status <= n_o_status;
        r_o_act    <= n_o_act;
        r_o_src    <= n_o_src;
        r_o_seq    <= n_o_seq;
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_status = r_o_status;
    assign o_alarm_active  = r_o_act;
    assign o_alarm_source  = r_o_src;
    assign o_alarm_seq     = r_o_seq;

endmodule
